// ===== sv/tcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// Text cell glyph renderer package
// Shared types, codes and cell geometry constants for the renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

    localparam int FONT_ENTRIES_DEF = 256;
    localparam int GLYPH_COLS       = 5;
    localparam int QUEUE_DEPTH      = 2;

    localparam int FUNC_W  = 2;
    localparam int CODE_W  = 8;
    localparam int FCOL_W  = 3;
    localparam int BITS_W  = 8;
    localparam int CUR_W   = 6;
    localparam int COLOR_W = 4;
    localparam int LIMIT_W = 9;
    localparam int PX_W    = 9;
    localparam int PY_W    = 10;
    localparam int REG_IDX_W = 2;
    localparam int PIX_CNT_W = 6;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CURSOR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PRINT  = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_FG_COLOR  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BG_COLOR  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LINE_LIMIT = 2'd2;

    localparam logic [COLOR_W-1:0] FG_RESET    = 4'd15;
    localparam logic [COLOR_W-1:0] BG_RESET    = 4'd0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd234;

    localparam logic [CODE_W-1:0]    NEWLINE_CODE = 8'd10;
    localparam logic [FCOL_W-1:0]    GLYPH_LAST_COL = 3'd4;
    localparam logic [PIX_CNT_W-1:0] PAD_TB_END  = 6'd12;
    localparam logic [PIX_CNT_W-1:0] PAD_R_END   = 6'd22;
    localparam logic [PIX_CNT_W-1:0] PIX_LAST    = 6'd61;
    localparam logic [2:0]           FETCH_DONE  = 3'd6;
    localparam logic [2:0]           RIGHT_PAD_X = 3'd5;
    localparam logic [3:0]           BOTTOM_PAD_Y = 4'd9;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_CURSOR,
        OP_PRINT
    } op_t;

    typedef enum logic [0:0] {
        B_IDLE,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        op_t               op;
        logic [CODE_W-1:0] char_code;
        logic [FCOL_W-1:0] font_column;
        logic [BITS_W-1:0] glyph_bits;
        logic [CUR_W-1:0]  set_col;
        logic [CUR_W-1:0]  set_row;
        logic              first_of_string;
    } cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0] ink_color;
        logic [COLOR_W-1:0] paper_color;
        logic [LIMIT_W-1:0] line_limit_px;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

endpackage

// ===== sv/tcgr_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one renderer item.
// ----------------------------------------------------------------------------
interface tcgr_cmd_if
    import tcgr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CODE_W-1:0] char_code;
    logic [FCOL_W-1:0] font_column;
    logic [BITS_W-1:0] glyph_bits;
    logic [CUR_W-1:0]  set_col;
    logic [CUR_W-1:0]  set_row;
    logic              first_of_string;

    modport source (
        output valid, func, char_code, font_column, glyph_bits, set_col, set_row,
               first_of_string,
        input  ready
    );

    modport sink (
        input  valid, func, char_code, font_column, glyph_bits, set_col, set_row,
               first_of_string,
        output ready
    );
endinterface

// ===== sv/tcgr_pix_if.sv =====
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one pixel write.
// ----------------------------------------------------------------------------
interface tcgr_pix_if
    import tcgr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PX_W-1:0]    pixel_x;
    logic [PY_W-1:0]    pixel_y;
    logic [COLOR_W-1:0] color;
    logic               last;

    modport source (
        output valid, pixel_x, pixel_y, color, last,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, color, last,
        output ready
    );
endinterface

// ===== sv/text_cell_glyph_renderer.sv =====
// ----------------------------------------------------------------------------
// Text cell glyph renderer
// Prints characters from a 5x8 bitmap font into 6x10 pixel cells.
// ----------------------------------------------------------------------------
// A print item produces 62 pixel items, one per cycle on the pixel port when
// the sink is ready, after the back end takes the item from the command
// queue. Glyph loads and cursor moves are taken from the queue only while the
// back end is idle; the pixel sequencer drives the port through a single
// output register. The glyph store is a memory of
// five bytes per character code with no clearing pass after reset; codes
// must be loaded before they are printed.
module text_cell_glyph_renderer
    import tcgr_pkg::*;
#(
    parameter int FONT_ENTRIES = FONT_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data,
    tcgr_cmd_if.sink             cmd,
    tcgr_pix_if.source           pix
);

    cfg_t          cfg_reg, cfg_next;
    queue_status_t q_status;
    logic          push;
    cmd_t          push_cmd;
    logic          pop;
    cmd_t          pop_cmd;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FG_COLOR:   cfg_next.ink_color     = cfg_data[COLOR_W-1:0];
                REG_BG_COLOR:   cfg_next.paper_color   = cfg_data[COLOR_W-1:0];
                REG_LINE_LIMIT: cfg_next.line_limit_px = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ink_color     <= FG_RESET;
            cfg_reg.paper_color   <= BG_RESET;
            cfg_reg.line_limit_px <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tcgr_front #(
        .FONT_ENTRIES (FONT_ENTRIES)
    ) u_front (
        .cmd      (cmd),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    tcgr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    tcgr_back #(
        .FONT_ENTRIES (FONT_ENTRIES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .q_cmd    (pop_cmd),
        .q_pop    (pop),
        .pix      (pix)
    );

endmodule

// ===== sv/tcgr_front.sv =====
// ----------------------------------------------------------------------------
// Renderer front end
// Accepts items, drops those with no effect and classifies the rest.
// ----------------------------------------------------------------------------
module tcgr_front
    import tcgr_pkg::*;
#(
    parameter int FONT_ENTRIES = FONT_ENTRIES_DEF
) (
    tcgr_cmd_if.sink cmd,
    input  queue_status_t q_status,
    output logic          push,
    output cmd_t          push_cmd
);

    localparam logic [CODE_W:0] FontLimit = (CODE_W+1)'(FONT_ENTRIES);

    logic accept;

    assign cmd.ready = !q_status.full;
    assign accept    = cmd.valid && !q_status.full;

    always_comb
    begin
        push_cmd.op              = OP_LOAD;
        push_cmd.char_code       = cmd.char_code;
        push_cmd.font_column     = cmd.font_column;
        push_cmd.glyph_bits      = cmd.glyph_bits;
        push_cmd.set_col         = cmd.set_col;
        push_cmd.set_row         = cmd.set_row;
        push_cmd.first_of_string = cmd.first_of_string;
        push                     = 1'b0;
        case (cmd.func)
            FUNC_LOAD:
            begin
                push_cmd.op = OP_LOAD;
                push = accept && ({1'b0, cmd.char_code} < FontLimit)
                       && (cmd.font_column <= GLYPH_LAST_COL);
            end
            FUNC_CURSOR:
            begin
                push_cmd.op = OP_CURSOR;
                push        = accept;
            end
            FUNC_PRINT:
            begin
                push_cmd.op = OP_PRINT;
                push        = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/tcgr_queue.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out store between the front and back ends.
// ----------------------------------------------------------------------------
module tcgr_queue
    import tcgr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cmd_t          push_cmd,
    input  logic          pop,
    output cmd_t          pop_cmd,
    output queue_status_t q_status
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

    cmd_t            entry_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign q_status.full      = (count_reg == CntFull);
    assign q_status.not_empty = (count_reg != '0);
    assign do_push = push && !q_status.full;
    assign do_pop  = pop && q_status.not_empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CntFull)
        else $error("command queue count exceeds its depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("command queue lost a push");
`endif

endmodule

// ===== sv/tcgr_back.sv =====
// ----------------------------------------------------------------------------
// Renderer back end
// Holds the glyph store and cursor, and sequences the pixel writes of a print.
// ----------------------------------------------------------------------------
module tcgr_back
    import tcgr_pkg::*;
#(
    parameter int FONT_ENTRIES = FONT_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  queue_status_t q_status,
    input  cmd_t          q_cmd,
    output logic          q_pop,
    tcgr_pix_if.source    pix
);

    localparam int MemDepth = FONT_ENTRIES * GLYPH_COLS;
    localparam int AddrW    = $clog2(MemDepth);

    back_state_t state_reg, state_next;

    logic [BITS_W-1:0]    mem [MemDepth];
    logic [BITS_W-1:0]    rd_data_reg;
    logic [BITS_W-1:0]    cols_reg [GLYPH_COLS];

    logic [CUR_W-1:0]     cur_col_reg, cur_col_next;
    logic [CUR_W-1:0]     cur_row_reg, cur_row_next;
    logic [CUR_W-1:0]     line_start_reg, line_start_next;
    logic [PIX_CNT_W-1:0] k_reg, k_next;
    logic [2:0]           fetch_cnt_reg, fetch_cnt_next;
    logic [PX_W-1:0]      base_x_reg, base_x_next;
    logic [PY_W-1:0]      base_y_reg, base_y_next;
    logic [AddrW-1:0]     glyph_base_reg, glyph_base_next;
    logic                 glyph_ok_reg, glyph_ok_next;
    logic                 newline_reg, newline_next;

    logic                 out_valid_reg, out_valid_next;
    logic [PX_W-1:0]      out_x_reg;
    logic [PY_W-1:0]      out_y_reg;
    logic [COLOR_W-1:0]   out_color_reg;
    logic                 out_last_reg;

    logic                 emit;
    logic                 start_print;
    logic                 mem_we;
    logic [AddrW-1:0]     mem_wr_addr;
    logic                 rd_en;
    logic [AddrW-1:0]     rd_addr;
    logic                 capture;
    logic [2:0]           capture_idx;

    logic [2:0]           x_off;
    logic [3:0]           y_off;
    logic                 pix_on;
    logic [PIX_CNT_W-1:0] g;
    logic [PX_W-1:0]      pix_x;
    logic [PY_W-1:0]      pix_y;
    logic [CUR_W:0]       col_plus;
    logic [LIMIT_W-1:0]   col_plus_px;
    logic                 wrap;

    assign emit        = (state_reg == B_EMIT) && (!out_valid_reg || pix.ready);
    assign q_pop       = (state_reg == B_IDLE) && q_status.not_empty;
    assign start_print = q_pop && (q_cmd.op == OP_PRINT);
    assign mem_we      = q_pop && (q_cmd.op == OP_LOAD);
    assign mem_wr_addr = AddrW'({q_cmd.char_code, 2'b00}) + AddrW'(q_cmd.char_code)
                         + AddrW'(q_cmd.font_column);

    assign rd_en       = (state_reg == B_EMIT) && glyph_ok_reg && (fetch_cnt_reg < 3'd5);
    assign rd_addr     = glyph_base_reg + AddrW'(fetch_cnt_reg);
    assign capture     = (state_reg == B_EMIT) && (fetch_cnt_reg != 3'd0)
                         && (fetch_cnt_reg != FETCH_DONE);
    assign capture_idx = fetch_cnt_reg - 3'd1;

    always_comb
    begin
        g      = k_reg - PAD_R_END;
        x_off  = g[5:3];
        y_off  = {1'b0, g[2:0]} + 4'd1;
        pix_on = glyph_ok_reg && cols_reg[g[5:3]][~g[2:0]];
        if (k_reg < PAD_TB_END)
        begin
            x_off  = k_reg[3:1];
            y_off  = k_reg[0] ? BOTTOM_PAD_Y : 4'd0;
            pix_on = 1'b0;
        end
        else if (k_reg < PAD_R_END)
        begin
            x_off  = RIGHT_PAD_X;
            y_off  = 4'(k_reg - PAD_TB_END);
            pix_on = 1'b0;
        end
        pix_x = base_x_reg + PX_W'(x_off);
        pix_y = base_y_reg + PY_W'(y_off);
    end

    assign col_plus    = {1'b0, cur_col_reg} + 1'b1;
    assign col_plus_px = LIMIT_W'({col_plus, 2'b00}) + LIMIT_W'({col_plus, 1'b0});
    assign wrap        = (col_plus_px > cfg.line_limit_px) || newline_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (start_print)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (emit && (k_reg == PIX_LAST))
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        line_start_next = line_start_reg;
        k_next          = k_reg;
        fetch_cnt_next  = fetch_cnt_reg;
        base_x_next     = base_x_reg;
        base_y_next     = base_y_reg;
        glyph_base_next = glyph_base_reg;
        glyph_ok_next   = glyph_ok_reg;
        newline_next    = newline_reg;
        out_valid_next  = pix.ready ? 1'b0 : out_valid_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_pop && (q_cmd.op == OP_CURSOR))
                begin
                    cur_col_next = q_cmd.set_col;
                    cur_row_next = q_cmd.set_row;
                end
                if (start_print)
                begin
                    if (q_cmd.first_of_string)
                    begin
                        line_start_next = cur_col_reg;
                    end
                    k_next          = '0;
                    fetch_cnt_next  = '0;
                    base_x_next     = PX_W'({cur_col_reg, 2'b00}) + PX_W'({cur_col_reg, 1'b0});
                    base_y_next     = PY_W'({cur_row_reg, 3'b000}) + PY_W'({cur_row_reg, 1'b0});
                    glyph_base_next = AddrW'({q_cmd.char_code, 2'b00}) + AddrW'(q_cmd.char_code);
                    glyph_ok_next   = ({1'b0, q_cmd.char_code} < (CODE_W+1)'(FONT_ENTRIES));
                    newline_next    = (q_cmd.char_code == NEWLINE_CODE);
                end
            end
            B_EMIT:
            begin
                if (fetch_cnt_reg != FETCH_DONE)
                begin
                    fetch_cnt_next = fetch_cnt_reg + 3'd1;
                end
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    k_next         = k_reg + 1'b1;
                    if (k_reg == PIX_LAST)
                    begin
                        if (wrap)
                        begin
                            cur_col_next = line_start_reg;
                            cur_row_next = cur_row_reg + 1'b1;
                        end
                        else
                        begin
                            cur_col_next = col_plus[CUR_W-1:0];
                        end
                    end
                end
            end
            default:
            begin
                k_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            line_start_reg <= '0;
            k_reg          <= '0;
            fetch_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            line_start_reg <= line_start_next;
            k_reg          <= k_next;
            fetch_cnt_reg  <= fetch_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_x_reg     <= base_x_next;
        base_y_reg     <= base_y_next;
        glyph_base_reg <= glyph_base_next;
        glyph_ok_reg   <= glyph_ok_next;
        newline_reg    <= newline_next;
        if (emit)
        begin
            out_x_reg     <= pix_x;
            out_y_reg     <= pix_y;
            out_color_reg <= pix_on ? cfg.ink_color : cfg.paper_color;
            out_last_reg  <= (k_reg == PIX_LAST);
        end
        if (capture)
        begin
            cols_reg[capture_idx] <= rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wr_addr] <= q_cmd.glyph_bits;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign pix.valid   = out_valid_reg;
    assign pix.pixel_x = out_x_reg;
    assign pix.pixel_y = out_y_reg;
    assign pix.color   = out_color_reg;
    assign pix.last    = out_last_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EMIT) |-> (k_reg <= PIX_LAST))
        else $error("pixel counter ran past the end of the cell");
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == B_EMIT) && (k_reg >= PAD_R_END)) |-> (fetch_cnt_reg == FETCH_DONE))
        else $error("glyph pixels reached before the glyph columns were fetched");
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (k_reg == PIX_LAST)) |=> (state_reg == B_IDLE && out_valid_reg && pix.last))
        else $error("final pixel not flagged or sequencer not back to idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EMIT) |-> !q_pop)
        else $error("command taken from the queue during a print");
`endif

endmodule
